@@ hw/rtl/ncc_pkg.sv @@
package ncc_pkg;

  // fixed sizes of the classifier
  localparam int unsigned NumClasses   = 6;
  localparam int unsigned SampleBits   = 12;
  localparam int unsigned CountBits    = 16;
  localparam int unsigned ClassBits    = 3;
  localparam int unsigned DistBits     = 2 * SampleBits + 2;
  localparam int unsigned CellCount    = NumClasses * NumClasses;
  localparam int unsigned CellAddrBits = $clog2(CellCount);
  localparam int unsigned CentroidBits = 3 * SampleBits;

  // stream and register port sizes
  localparam int unsigned InDataBits   = 48;
  localparam int unsigned OutDataBits  = 48;
  localparam int unsigned RegAddrBits  = 3;
  localparam int unsigned RegDataBits  = 32;

  localparam logic [DistBits-1:0] DistanceLimitReset = DistBits'(100000);
  localparam logic                RegIdxLimit        = 1'b0;

  typedef enum logic [1:0] {
    ACT_CLASSIFY = 2'd0,
    ACT_LOAD     = 2'd1,
    ACT_CLEAR    = 2'd2,
    ACT_READ     = 2'd3
  } action_e;

  // input beat, x in the lowest bits
  typedef struct packed {
    action_e                action;
    logic [ClassBits-1:0]   class_index;
    logic [ClassBits-1:0]   true_class;
    logic [SampleBits-1:0]  z;
    logic [SampleBits-1:0]  y;
    logic [SampleBits-1:0]  x;
  } item_t;

  // classifier decision
  typedef struct packed {
    logic [DistBits-1:0]  best_dist;
    logic                 mismatch;
    logic [ClassBits-1:0] pred;
  } class_res_t;

  // counter operation carried by the second stage
  typedef struct packed {
    logic                    count_en;
    logic                    read_en;
    logic                    clear;
    logic [CellAddrBits-1:0] addr;
  } cnt_op_t;

  // result beat, predicted class in the lowest bits
  typedef struct packed {
    logic [CountBits-1:0] cell_cnt;
    class_res_t           res;
  } out_t;

  // flat matrix address of a row and column
  function automatic logic [CellAddrBits-1:0] cell_addr(input logic [ClassBits-1:0] row,
                                                        input logic [ClassBits-1:0] col);
    cell_addr = CellAddrBits'(row * NumClasses + col);
  endfunction

endpackage

@@ hw/rtl/ncc_ram.sv @@
module ncc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 36
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port, read returns old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/ncc_classify.sv @@
module ncc_classify (
  input  logic                         clk_i,
  input  logic                         load_en_i,
  input  ncc_pkg::item_t               item_i,
  input  logic [ncc_pkg::DistBits-1:0] limit_i,
  output ncc_pkg::class_res_t          res_o
);
  import ncc_pkg::*;

  logic [CentroidBits-1:0] centroid_q [NumClasses];
  logic [DistBits-1:0]     dist_w [NumClasses];

  // centroid store, written by load beats
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumClasses; i++) begin
      if (load_en_i && item_i.class_index == ClassBits'(i)) begin
        centroid_q[i] <= {item_i.z, item_i.y, item_i.x};
      end
    end
  end

  // squared euclidean distance to every centroid in parallel
  always_comb begin
    logic [SampleBits-1:0]   cx, cy, cz;
    logic [SampleBits-1:0]   dx, dy, dz;
    logic [2*SampleBits-1:0] sx, sy, sz;
    for (int i = 0; i < NumClasses; i++) begin
      cx = centroid_q[i][SampleBits-1:0];
      cy = centroid_q[i][2*SampleBits-1:SampleBits];
      cz = centroid_q[i][3*SampleBits-1:2*SampleBits];
      dx = (cx >= item_i.x) ? cx - item_i.x : item_i.x - cx;
      dy = (cy >= item_i.y) ? cy - item_i.y : item_i.y - cy;
      dz = (cz >= item_i.z) ? cz - item_i.z : item_i.z - cz;
      sx = dx * dx;
      sy = dy * dy;
      sz = dz * dz;
      dist_w[i] = DistBits'(sx) + DistBits'(sy) + DistBits'(sz);
    end
  end

  // strict-less scan from the limit, ties keep the lower index
  always_comb begin
    logic [DistBits-1:0]  best;
    logic [ClassBits-1:0] pred;
    best = limit_i;
    pred = '0;
    for (int i = 0; i < NumClasses; i++) begin
      if (dist_w[i] < best) begin
        best = dist_w[i];
        pred = ClassBits'(i);
      end
    end
    res_o.best_dist = best;
    res_o.pred      = pred;
    res_o.mismatch  = (pred != item_i.true_class);
  end

endmodule

@@ hw/rtl/ncc_counts.sv @@
module ncc_counts (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rd_en_i,
  input  logic [ncc_pkg::CellAddrBits-1:0] rd_addr_i,
  input  logic                             commit_i,
  input  ncc_pkg::cnt_op_t                 op_i,
  output logic [ncc_pkg::CountBits-1:0]    cell_o
);
  import ncc_pkg::*;

  logic [CellCount-1:0]  valid_q;
  logic                  hit_q;
  logic [CountBits-1:0]  fwd_q;
  logic [CountBits-1:0]  rdata;
  logic [CountBits-1:0]  old_val;
  logic [CountBits-1:0]  inc_val;
  logic                  entry_valid;
  logic                  wr_en;

  assign wr_en = commit_i && op_i.count_en;

  ncc_ram #(
    .Width (CountBits),
    .Depth (CellCount)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (op_i.addr),
    .wdata_i (inc_val),
    .re_i    (rd_en_i),
    .raddr_i (rd_addr_i),
    .rdata_o (rdata)
  );

  // catch a write to the same cell in the cycle of the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (rd_en_i) begin
      hit_q <= wr_en && (op_i.addr == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_q <= inc_val;
    end
  end

  // per-cell valid bits, a clear drops them all at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (commit_i && op_i.clear) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[op_i.addr] <= 1'b1;
    end
  end

  // current value of the cell, then saturating increment
  always_comb begin
    entry_valid = (op_i.addr < CellAddrBits'(CellCount)) ? valid_q[op_i.addr] : 1'b0;
    if (!entry_valid) begin
      old_val = '0;
    end else if (hit_q) begin
      old_val = fwd_q;
    end else begin
      old_val = rdata;
    end
    inc_val = (old_val == '1) ? old_val : old_val + 1'b1;
    priority if (op_i.count_en) begin
      cell_o = inc_val;
    end else if (op_i.read_en) begin
      cell_o = old_val;
    end else begin
      cell_o = '0;
    end
  end

endmodule

@@ hw/rtl/nearest_centroid_confusion_counter_top.sv @@
// nearest centroid classifier with confusion matrix counters
//
// input stream: one beat per action. tuser carries the action (classify and
// count, load centroid, clear counts, read count cell); tdata carries the
// sample or centroid coordinates, the true class and the class index.
// output stream: exactly one result beat for every input beat, in order.
// classify returns the nearest centroid, the mismatch flag, the winning
// squared distance and the updated matrix cell; read returns the addressed
// cell; load and clear return zeros.
// the apb port holds distance_limit at byte address 0; write it only while
// the stream is idle.
// path: the result beat passes the input register, the counter stage (counter
// read) and the result register before it is valid.
// throughput: one beat per cycle unless stalled; the matrix lives in a ram with
// one read and one write port; a bypass covers back-to-back same-cell updates.
// reset clears the pipeline, all matrix counts and restores the limit to
// 100000; centroids must be loaded before the first classify.
// when the receiver stalls, the result is held and the stages behind it keep
// filling; s_axis_tready drops only once all three stages are full.
module nearest_centroid_confusion_counter_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // x[11:0], y[23:12], z[35:24], true_class[38:36], class_index[41:39]
  input  logic [ncc_pkg::InDataBits-1:0]     s_axis_tdata,
  // action[1:0]
  input  logic [1:0]                         s_axis_tuser,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // predicted_class[2:0], mismatch[3], best_distance[29:4], cell_count[45:30]
  output logic [ncc_pkg::OutDataBits-1:0]    m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ncc_pkg::RegAddrBits-1:0]    paddr,
  input  logic [ncc_pkg::RegDataBits-1:0]    pwdata,
  output logic [ncc_pkg::RegDataBits-1:0]    prdata,
  output logic                               pready
);
  import ncc_pkg::*;

  localparam int unsigned ItemBits = $bits(item_t);

  logic                 limit_wr;
  logic [DistBits-1:0]  limit_q;
  logic                 s1_valid_q;
  item_t                s1_item_q;
  logic                 s2_valid_q;
  class_res_t           s2_res_q;
  cnt_op_t              s2_op_q;
  logic                 out_valid_q;
  out_t                 out_q;
  logic                 ready_out;
  logic                 s2_ready;
  logic                 s2_commit;
  logic                 s1_adv;
  logic                 load_en;
  class_res_t           cls_res;
  class_res_t           s2_res_d;
  cnt_op_t              s2_op_d;
  logic                 row_ok;
  logic                 col_ok;
  logic [CountBits-1:0] cell_val;

  // register port
  assign pready   = 1'b1;
  assign limit_wr = psel && penable && pwrite && pready
                    && (paddr[RegAddrBits-1] == RegIdxLimit);
  assign prdata   = (paddr[RegAddrBits-1] == RegIdxLimit) ? RegDataBits'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= DistanceLimitReset;
    end else if (limit_wr) begin
      limit_q <= pwdata[DistBits-1:0];
    end
  end

  // stage handshakes
  assign ready_out     = !out_valid_q || m_axis_tready;
  assign s2_ready      = !s2_valid_q || ready_out;
  assign s2_commit     = s2_valid_q && ready_out;
  assign s1_adv        = s1_valid_q && s2_ready;
  assign s_axis_tready = !s1_valid_q || s2_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_item_q <= item_t'({s_axis_tuser, s_axis_tdata[ItemBits-3:0]});
    end
  end

  // distances, argmin and centroid store
  assign load_en = s1_adv && (s1_item_q.action == ACT_LOAD)
                   && (s1_item_q.class_index < ClassBits'(NumClasses));

  ncc_classify u_classify (
    .clk_i     (clk_i),
    .load_en_i (load_en),
    .item_i    (s1_item_q),
    .limit_i   (limit_q),
    .res_o     (cls_res)
  );

  // decode the counter operation for the next stage
  always_comb begin
    row_ok            = s1_item_q.true_class < ClassBits'(NumClasses);
    col_ok            = s1_item_q.class_index < ClassBits'(NumClasses);
    s2_res_d          = '0;
    s2_op_d.count_en  = 1'b0;
    s2_op_d.read_en   = 1'b0;
    s2_op_d.clear     = 1'b0;
    s2_op_d.addr      = cell_addr(s1_item_q.true_class, s1_item_q.class_index);
    unique case (s1_item_q.action)
      ACT_CLASSIFY: begin
        s2_res_d         = cls_res;
        s2_op_d.count_en = row_ok;
        s2_op_d.addr     = cell_addr(s1_item_q.true_class, cls_res.pred);
      end
      ACT_LOAD: begin
      end
      ACT_CLEAR: begin
        s2_op_d.clear = 1'b1;
      end
      ACT_READ: begin
        s2_op_d.read_en = row_ok && col_ok;
      end
      default: begin
      end
    endcase
  end

  // counter stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_op_q    <= '0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        s2_op_q <= s2_op_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_res_q <= s2_res_d;
    end
  end

  // confusion matrix read-modify-write
  ncc_counts u_counts (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s1_adv && (s2_op_d.count_en || s2_op_d.read_en)),
    .rd_addr_i (s2_op_d.addr),
    .commit_i  (s2_commit),
    .op_i      (s2_op_q),
    .cell_o    (cell_val)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_out) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_commit) begin
      out_q.res      <= s2_res_q;
      out_q.cell_cnt <= cell_val;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataBits'(out_q);

`ifndef SYNTHESIS
  // a stalled counter stage keeps its beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !ready_out |=> s2_valid_q)
    else $error("counter stage lost a beat while stalled");

  // a counted classify never reports a zero cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_commit && s2_op_q.count_en |=> out_q.cell_cnt != '0)
    else $error("counted cell reads zero");

  // the reported distance never exceeds the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.res.best_dist <= limit_q)
    else $error("best distance above limit");

  // predicted class is a real centroid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.res.pred < ClassBits'(NumClasses))
    else $error("predicted class out of range");
`endif

endmodule
